[rtl/pgw_pkg.sv]
package pgw_pkg;

  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int ENTRY_W = 64;
  localparam int IDX_W   = 9;
  localparam int LVL_W   = 2;

  // Command codes on the input channel.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_ENTRY = 1'b1;

  // Result kinds.
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Table levels, named by the entry that is awaited.
  localparam logic [LVL_W-1:0] LVL_TOP = 2'd0;
  localparam logic [LVL_W-1:0] LVL_L2  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_L3  = 2'd2;
  localparam logic [LVL_W-1:0] LVL_L4  = 2'd3;

  // Entry flag positions.
  localparam int PRESENT_BIT = 0;
  localparam int LARGE_BIT   = 7;

  // Page offset masks for 1 GiB, 2 MiB and 4 KiB pages.
  localparam logic [VA_W-1:0] OFF_1G = 48'h0000_3FFF_FFFF;
  localparam logic [VA_W-1:0] OFF_2M = 48'h0000_001F_FFFF;
  localparam logic [VA_W-1:0] OFF_4K = 48'h0000_0000_0FFF;

  typedef struct packed {
    logic              busy;
    logic [LVL_W-1:0]  level;
    logic [VA_W-1:0]   va;
  } walk_st_t;

  typedef struct packed {
    logic             kind;
    logic [PA_W-1:0]  phys_addr;
    logic             fault;
  } result_t;

  // Nine-bit table index of a virtual address for a given level.
  function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                   input logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      LVL_TOP: idx = va[47:39];
      LVL_L2:  idx = va[38:30];
      LVL_L3:  idx = va[29:21];
      LVL_L4:  idx = va[20:12];
      default: idx = va[47:39];
    endcase
    return idx;
  endfunction

  // Byte address of an entry: table base plus eight times the index, mod 2^52.
  function automatic logic [PA_W-1:0] entry_addr(input logic [PA_W-1:0] base,
                                                 input logic [IDX_W-1:0] idx);
    return base + {{(PA_W-IDX_W-3){1'b0}}, idx, 3'b000};
  endfunction

endpackage

[rtl/pgw_if.sv]
interface pgw_item_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [pgw_pkg::VA_W-1:0]      virt_addr;
  logic [pgw_pkg::ENTRY_W-1:0]   entry_data;

  modport source (output valid, output cmd, output virt_addr, output entry_data,
                  input ready);
  modport sink (input valid, input cmd, input virt_addr, input entry_data,
                output ready);
endinterface

interface pgw_result_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [pgw_pkg::PA_W-1:0]  phys_addr;
  logic                      fault;

  modport source (output valid, output kind, output phys_addr, output fault,
                  input ready);
  modport sink (input valid, input kind, input phys_addr, input fault,
                output ready);
endinterface

interface pgw_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [pgw_pkg::PA_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/pgw_step.sv]
module pgw_step (
  input  logic                         cmd,
  input  logic [pgw_pkg::VA_W-1:0]     virt_addr,
  input  logic [pgw_pkg::ENTRY_W-1:0]  entry_data,
  input  logic [pgw_pkg::PA_W-1:0]     root_base,
  input  pgw_pkg::walk_st_t            st,
  output pgw_pkg::walk_st_t            st_nxt,
  output logic                         emit,
  output pgw_pkg::result_t             res
);

  logic                         present;
  logic                         is_large;
  logic [pgw_pkg::PA_W-1:0]     frame;
  logic [pgw_pkg::VA_W-1:0]     off_mask;
  logic [pgw_pkg::PA_W-1:0]     page_pa;
  logic [pgw_pkg::LVL_W-1:0]    next_lvl;

  assign present  = entry_data[pgw_pkg::PRESENT_BIT];
  assign is_large = entry_data[pgw_pkg::LARGE_BIT];
  assign frame    = {entry_data[51:12], 12'h000};
  assign next_lvl = st.level + 2'd1;

  always_comb begin
    case (st.level)
      pgw_pkg::LVL_L2: off_mask = pgw_pkg::OFF_1G;
      pgw_pkg::LVL_L3: off_mask = pgw_pkg::OFF_2M;
      default:         off_mask = pgw_pkg::OFF_4K;
    endcase
  end

  // Large-page frames may carry low bits; they take part in the sum.
  assign page_pa = frame + {{(pgw_pkg::PA_W-pgw_pkg::VA_W){1'b0}}, st.va & off_mask};

  always_comb begin
    st_nxt        = st;
    emit          = 1'b0;
    res.kind      = pgw_pkg::KIND_READ;
    res.phys_addr = '0;
    res.fault     = 1'b0;
    if (cmd == pgw_pkg::CMD_START) begin
      if (!st.busy) begin
        st_nxt.busy   = 1'b1;
        st_nxt.level  = pgw_pkg::LVL_TOP;
        st_nxt.va     = virt_addr;
        emit          = 1'b1;
        res.phys_addr = pgw_pkg::entry_addr(root_base,
                          pgw_pkg::level_index(virt_addr, pgw_pkg::LVL_TOP));
      end
    end else if (st.busy) begin
      emit = 1'b1;
      if (!present || (st.level == pgw_pkg::LVL_TOP && is_large)) begin
        st_nxt.busy  = 1'b0;
        st_nxt.level = pgw_pkg::LVL_TOP;
        res.kind     = pgw_pkg::KIND_DONE;
        res.fault    = 1'b1;
      end else if (is_large || st.level == pgw_pkg::LVL_L4) begin
        st_nxt.busy   = 1'b0;
        st_nxt.level  = pgw_pkg::LVL_TOP;
        res.kind      = pgw_pkg::KIND_DONE;
        res.phys_addr = page_pa;
      end else begin
        st_nxt.level  = next_lvl;
        res.phys_addr = pgw_pkg::entry_addr(frame,
                          pgw_pkg::level_index(st.va, next_lvl));
      end
    end
  end

endmodule

[rtl/pgw_out_reg.sv]
module pgw_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  pgw_pkg::result_t   res,
  output logic               can_load,
  pgw_result_if.source       out_ch
);

  logic              valid_r;
  logic              valid_nxt;
  pgw_pkg::result_t  data_r;

  assign can_load = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.kind      = data_r.kind;
  assign out_ch.phys_addr = data_r.phys_addr;
  assign out_ch.fault     = data_r.fault;

endmodule

[rtl/four_level_page_walker.sv]
// Four-level page table walker for 48-bit virtual addresses. Software writes
// the physical base of the top-level table on the cfg channel while the block
// is idle. A start transfer (cmd 0) latches the virtual address and produces a
// read request (kind 0) for the top-level entry. The memory side answers each
// request with an entry transfer (cmd 1); the walker then requests the next
// level's entry or produces a finished translation (kind 1) carrying the
// physical address, or fault 1 with address zero for a non-present entry or a
// large page at the top level. A start during a walk and an entry outside a
// walk are taken and dropped without a result. Each input transfer is handled
// in the cycle it is accepted, and its result appears in the output register
// in the following cycle; the block takes one transfer per cycle, and stalls
// only while that output register holds a result the sink has not taken.
module four_level_page_walker (
  input  logic          clk,
  input  logic          rst_n,
  pgw_cfg_if.sink       cfg_ch,
  pgw_item_if.sink      in_ch,
  pgw_result_if.source  out_ch
);

  logic [pgw_pkg::PA_W-1:0]  root_r;
  pgw_pkg::walk_st_t         st_r;
  pgw_pkg::walk_st_t         st_nxt;
  logic                      emit;
  pgw_pkg::result_t          res;
  logic                      can_load;
  logic                      in_xfer;

  // Root always writable; the user must write it only while idle, unchecked.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
    end else if (cfg_ch.valid) begin
      root_r <= cfg_ch.data;
    end
  end

  // An input transfer is accepted whenever the output register is free or is
  // being emptied in the same cycle, so results can stream back to back.
  assign in_ch.ready = can_load;
  assign in_xfer     = in_ch.valid && can_load;

  pgw_step u_step (
    .cmd        (in_ch.cmd),
    .virt_addr  (in_ch.virt_addr),
    .entry_data (in_ch.entry_data),
    .root_base  (root_r),
    .st         (st_r),
    .st_nxt     (st_nxt),
    .emit       (emit),
    .res        (res)
  );

  // Walk state advances only on an accepted transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  pgw_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_xfer && emit),
    .res      (res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

`ifndef SYNTH
  // A start during a walk must leave the saved address untouched.
  a_start_busy_keeps_va: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_ch.cmd == pgw_pkg::CMD_START && st_r.busy
    |=> st_r.busy && st_r.va == $past(st_r.va))
    else $error("start during a walk disturbed the walk state");

  // A finished translation ends the walk.
  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && emit && res.kind == pgw_pkg::KIND_DONE |=> !st_r.busy)
    else $error("walker still busy after a finished translation");

  // A read request keeps the walker busy.
  a_read_stays_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && emit && res.kind == pgw_pkg::KIND_READ |=> st_r.busy)
    else $error("walker idle after issuing a read request");

  // A fault is always a finished translation with address zero.
  a_fault_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.fault
    |-> out_ch.kind == pgw_pkg::KIND_DONE && out_ch.phys_addr == '0)
    else $error("malformed fault result");
`endif

endmodule
